[sv/sbta_pkg.sv]
// shared constants, command codes and interface types for the triple-angle sine block
package sbta_pkg;

    localparam int P_MAX_DIVIDES     = 8;
    localparam int P_ANGLE_FRAC_BITS = 28;

    localparam int ANGLE_W = 32;
    localparam int LIMIT_W = 29;
    localparam int SINE_W  = 32;
    localparam int MUL_W   = 34;
    localparam int PROD_W  = 2 * MUL_W;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 29'd42165842;
    // ceil(2^33 / 3), exact floor division by three for operands below 2^33
    localparam logic [MUL_W-1:0]   RECIP3      = 34'h0_AAAA_AAAB;
    localparam logic [PROD_W-1:0]  ROUND_HALF  = 68'h2000_0000;

    localparam int CMD_W = 4;
    localparam logic [CMD_W-1:0] CMD_NONE       = 4'd0;
    localparam logic [CMD_W-1:0] CMD_LOAD       = 4'd1;
    localparam logic [CMD_W-1:0] CMD_DIV_M      = 4'd2;
    localparam logic [CMD_W-1:0] CMD_WB_M       = 4'd3;
    localparam logic [CMD_W-1:0] CMD_XCONV      = 4'd4;
    localparam logic [CMD_W-1:0] CMD_MUL_XX     = 4'd5;
    localparam logic [CMD_W-1:0] CMD_WB_T       = 4'd6;
    localparam logic [CMD_W-1:0] CMD_MUL_TX     = 4'd7;
    localparam logic [CMD_W-1:0] CMD_DIV_X3     = 4'd8;
    localparam logic [CMD_W-1:0] CMD_WB_TAYLOR  = 4'd9;
    localparam logic [CMD_W-1:0] CMD_MUL_SS     = 4'd10;
    localparam logic [CMD_W-1:0] CMD_MUL_TS     = 4'd11;
    localparam logic [CMD_W-1:0] CMD_WB_TRIPLE  = 4'd12;
    localparam logic [CMD_W-1:0] CMD_OUT        = 4'd13;

    typedef struct packed {
        logic [CMD_W-1:0] op;
    } t_dp_cmd;

    typedef struct packed {
        logic need_div;
        logic k_zero;
    } t_dp_status;

    function automatic logic signed [SINE_W-1:0] f_clamp_one(input logic signed [35:0] v);
        if (v > 36'sd1073741824) begin
            return 32'sd1073741824;
        end else if (v < -36'sd1073741824) begin
            return -32'sd1073741824;
        end else begin
            return v[SINE_W-1:0];
        end
    endfunction

endpackage

[sv/sbta_ctrl.sv]
// sequencer: divide loop, taylor cubic and triple-angle steps, output handoff
module sbta_ctrl import sbta_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_CHECK  = 4'd1;
    localparam logic [3:0] S_DIVWB  = 4'd2;
    localparam logic [3:0] S_XX     = 4'd3;
    localparam logic [3:0] S_X2WB   = 4'd4;
    localparam logic [3:0] S_X3MUL  = 4'd5;
    localparam logic [3:0] S_X3WB   = 4'd6;
    localparam logic [3:0] S_X6     = 4'd7;
    localparam logic [3:0] S_TAYWB  = 4'd8;
    localparam logic [3:0] S_TRI    = 4'd9;
    localparam logic [3:0] S_SQWB   = 4'd10;
    localparam logic [3:0] S_CUBE   = 4'd11;
    localparam logic [3:0] S_TRIWB  = 4'd12;
    localparam logic [3:0] S_OUT    = 4'd13;

    logic [3:0] r_state;
    logic [3:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       out_load;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign out_load    = (r_state == S_OUT) && (!r_out_valid || i_out_ready);

    always_comb begin
        n_state = r_state;
        o_cmd.op = CMD_NONE;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = CMD_LOAD;
                    n_state  = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_status.need_div) begin
                    o_cmd.op = CMD_DIV_M;
                    n_state  = S_DIVWB;
                end else begin
                    o_cmd.op = CMD_XCONV;
                    n_state  = S_XX;
                end
            end
            S_DIVWB: begin
                o_cmd.op = CMD_WB_M;
                n_state  = S_CHECK;
            end
            S_XX: begin
                o_cmd.op = CMD_MUL_XX;
                n_state  = S_X2WB;
            end
            S_X2WB: begin
                o_cmd.op = CMD_WB_T;
                n_state  = S_X3MUL;
            end
            S_X3MUL: begin
                o_cmd.op = CMD_MUL_TX;
                n_state  = S_X3WB;
            end
            S_X3WB: begin
                o_cmd.op = CMD_WB_T;
                n_state  = S_X6;
            end
            S_X6: begin
                o_cmd.op = CMD_DIV_X3;
                n_state  = S_TAYWB;
            end
            S_TAYWB: begin
                o_cmd.op = CMD_WB_TAYLOR;
                n_state  = S_TRI;
            end
            S_TRI: begin
                if (i_status.k_zero) begin
                    n_state = S_OUT;
                end else begin
                    o_cmd.op = CMD_MUL_SS;
                    n_state  = S_SQWB;
                end
            end
            S_SQWB: begin
                o_cmd.op = CMD_WB_T;
                n_state  = S_CUBE;
            end
            S_CUBE: begin
                o_cmd.op = CMD_MUL_TS;
                n_state  = S_TRIWB;
            end
            S_TRIWB: begin
                o_cmd.op = CMD_WB_TRIPLE;
                n_state  = S_TRI;
            end
            S_OUT: begin
                if (out_load) begin
                    o_cmd.op = CMD_OUT;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

[sv/sbta_dp.sv]
// datapath: angle registers, shared multiplier, rounding, clamping and result register
module sbta_dp import sbta_pkg::*; #(
    parameter int MAX_DIVIDES     = P_MAX_DIVIDES,
    parameter int ANGLE_FRAC_BITS = P_ANGLE_FRAC_BITS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [LIMIT_W-1:0] i_cfg_wdata,
    input  logic [ANGLE_W-1:0] i_angle,
    input  t_dp_cmd            i_cmd,
    output t_dp_status         o_status,
    output logic [SINE_W-1:0]  o_sine,
    output logic               o_depth_limited
);

    localparam int KW  = $clog2(MAX_DIVIDES + 1);
    localparam int XSH = 30 - ANGLE_FRAC_BITS;
    localparam int XW  = ANGLE_W + XSH;
    localparam logic [XW-1:0] X_SAT = XW'(64'h8000_0000);

    logic [LIMIT_W-1:0]       r_limit;
    logic [ANGLE_W-1:0]       r_m;
    logic [KW-1:0]            r_k;
    logic [ANGLE_W-1:0]       r_x;
    logic [MUL_W-1:0]         r_t;
    logic signed [SINE_W-1:0] r_s;
    logic                     r_neg;
    logic                     r_limited;
    logic [PROD_W-1:0]        r_prod;
    logic [SINE_W-1:0]        r_sine;
    logic                     r_depth;

    logic [MUL_W-1:0]         mul_a;
    logic [MUL_W-1:0]         mul_b;
    logic [ANGLE_W-1:0]       in_mag;
    logic [XW-1:0]            x_wide;
    logic [PROD_W-1:0]        rnd_sum;
    logic [30:0]              s_mag;
    logic [MUL_W:0]           x3_plus;
    logic signed [35:0]       taylor_v;
    logic [35:0]              triple_u;
    logic signed [SINE_W-1:0] triple_c;
    logic                     m_above;

    assign in_mag   = i_angle[ANGLE_W-1] ? (~i_angle + 1'b1) : i_angle;
    assign x_wide   = XW'(r_m) << XSH;
    assign rnd_sum  = r_prod + ROUND_HALF;
    assign s_mag    = r_s[SINE_W-1] ? 31'(-r_s) : r_s[30:0];
    assign x3_plus  = {1'b0, r_t} + 35'd3;
    assign taylor_v = $signed({4'b0, r_x}) - $signed({3'b0, r_prod[65:33]});
    assign triple_u = (36'(s_mag) << 1) + 36'(s_mag) - (36'(rnd_sum[60:30]) << 2);
    assign triple_c = f_clamp_one($signed(triple_u));
    assign m_above  = r_m > ANGLE_W'(r_limit);

    assign o_status.need_div = m_above && (r_k < KW'(MAX_DIVIDES));
    assign o_status.k_zero   = (r_k == '0);
    assign o_sine            = r_sine;
    assign o_depth_limited   = r_depth;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (i_cmd.op)
            CMD_DIV_M: begin
                mul_a = MUL_W'(r_m) + 1'b1;
                mul_b = RECIP3;
            end
            CMD_MUL_XX: begin
                mul_a = MUL_W'(r_x);
                mul_b = MUL_W'(r_x);
            end
            CMD_MUL_TX: begin
                mul_a = r_t;
                mul_b = MUL_W'(r_x);
            end
            CMD_DIV_X3: begin
                mul_a = x3_plus[MUL_W:1];
                mul_b = RECIP3;
            end
            CMD_MUL_SS: begin
                mul_a = MUL_W'(s_mag);
                mul_b = MUL_W'(s_mag);
            end
            CMD_MUL_TS: begin
                mul_a = r_t;
                mul_b = MUL_W'(s_mag);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_RESET;
        end else if (i_cfg_we) begin
            r_limit <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        unique case (i_cmd.op)
            CMD_LOAD: begin
                r_m   <= in_mag;
                r_k   <= '0;
                r_neg <= i_angle[ANGLE_W-1];
            end
            CMD_WB_M: begin
                r_m <= r_prod[64:33];
                r_k <= r_k + 1'b1;
            end
            CMD_XCONV: begin
                r_x       <= (x_wide > X_SAT) ? ANGLE_W'(X_SAT) : ANGLE_W'(x_wide);
                r_limited <= m_above;
            end
            CMD_WB_T: begin
                r_t <= rnd_sum[63:30];
            end
            CMD_WB_TAYLOR: begin
                r_s <= f_clamp_one(taylor_v);
            end
            CMD_WB_TRIPLE: begin
                r_s <= r_s[SINE_W-1] ? -triple_c : triple_c;
                r_k <= r_k - 1'b1;
            end
            CMD_OUT: begin
                r_sine  <= r_neg ? 32'(-r_s) : 32'(r_s);
                r_depth <= r_limited;
            end
            default: begin
            end
        endcase
    end

endmodule

[sv/sine_by_triple_angle.sv]
// top level of the triple-angle sine block
//
// input stream s_axis: one angle per transfer, radians in two's complement with
// ANGLE_FRAC_BITS fraction bits. output stream m_axis: one result per angle, the sine
// in Q30 saturated to plus or minus one, with tuser set when the divide-by-three
// loop stopped at MAX_DIVIDES before the angle fell to the small-angle limit.
// i_cfg_we / i_cfg_wdata write the small-angle limit; write it only while idle.
// each divide step runs the CHECK and DIVWB states and each triple-angle step the TRI,
// SQWB, CUBE and TRIWB states, with as many triple-angle steps as divide steps (0 to
// MAX_DIVIDES), all sharing one registered 34x34 multiplier.
// one angle is worked on at a time; s_axis_tready is high only while the sequencer
// is idle, so no new angle is taken before the last one has left the sequencer.
// the result sits in an output register, so the next angle is taken while it waits;
// if the receiver stalls, the next result holds in the sequencer until the register
// frees up. reset clears the sequencer and output valid and restores the default
// limit of pi/20 rad.
module sine_by_triple_angle import sbta_pkg::*; #(
    parameter int MAX_DIVIDES     = P_MAX_DIVIDES,
    parameter int ANGLE_FRAC_BITS = P_ANGLE_FRAC_BITS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [LIMIT_W-1:0] i_cfg_wdata,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [ANGLE_W-1:0] s_axis_tdata,   // angle
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [SINE_W-1:0]  m_axis_tdata,   // sine
    output logic               m_axis_tuser    // depth_limited
);

    t_dp_cmd    cmd;
    t_dp_status status;

    sbta_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    sbta_dp #(
        .MAX_DIVIDES     (MAX_DIVIDES),
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_angle         (s_axis_tdata),
        .i_cmd           (cmd),
        .o_status        (status),
        .o_sine          (m_axis_tdata),
        .o_depth_limited (m_axis_tuser)
    );

endmodule

[sv/sbta_checker.sv]
// port-level checks for the triple-angle sine block, bound to the top level
module sbta_checker import sbta_pkg::*; (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               s_axis_tvalid,
    input logic               s_axis_tready,
    input logic               m_axis_tvalid,
    input logic               m_axis_tready,
    input logic [SINE_W-1:0]  m_axis_tdata,
    input logic               m_axis_tuser
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

    // one angle at a time
    a_busy_after_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken while busy");

    // sine stays within plus or minus one
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |->
            ($signed(m_axis_tdata) <= 32'sd1073741824) &&
            ($signed(m_axis_tdata) >= -32'sd1073741824))
        else $error("sine out of range");

    // a new result appears only at the end of a computation
    a_rise_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
        else $error("result appeared while idle");

endmodule

bind sine_by_triple_angle sbta_checker u_sbta_checker (.*);

[bench/tb.sv]
// self-checking testbench for the triple-angle sine block
module tb;
    import sbta_pkg::*;

    localparam int                 SETTLE_CYCLES = 70;
    localparam int                 PHASES        = 7;
    localparam int                 RANDOM_ITEMS  = 215;
    localparam logic [63:0]        Q30_HALF      = 64'h2000_0000;
    localparam logic [63:0]        X_MAX         = 64'h8000_0000;
    localparam longint             UNIT_Q30      = 64'sh4000_0000;
    localparam logic [LIMIT_W-1:0] LIMIT_ALL_ONES = 29'h1FFF_FFFF;
    localparam logic [LIMIT_W-1:0] LIMIT_ONE_RAD  = 29'h1000_0000;

    typedef struct packed {
        logic [SINE_W-1:0] sine;
        logic              depth_limited;
    } t_sine_result;

    class t_sine_scoreboard;
        t_sine_result       expected_sines[$];
        logic [LIMIT_W-1:0] limit = LIMIT_RESET;
        int                 mismatch_count = 0;

        function logic [63:0] round_q30(logic [63:0] a, logic [63:0] b);
            return (a * b + Q30_HALF) >> 30;
        endfunction

        function longint signed_q30(longint a, longint b);
            logic [63:0] ma;
            logic [63:0] mb;
            logic [63:0] p;
            ma = (a < 0) ? -a : a;
            mb = (b < 0) ? -b : b;
            p = round_q30(ma, mb);
            return ((a < 0) != (b < 0)) ? -longint'(p) : longint'(p);
        endfunction

        function longint saturate_unit(longint v);
            if (v > UNIT_Q30) return UNIT_Q30;
            if (v < -UNIT_Q30) return -UNIT_Q30;
            return v;
        endfunction

        function t_sine_result predict_sine(logic [ANGLE_W-1:0] angle);
            t_sine_result r;
            logic [32:0]  mag;
            int           steps;
            logic [63:0]  x;
            logic [63:0]  x2;
            logic [63:0]  x3;
            longint       s;
            longint       cube;
            mag = angle[ANGLE_W-1] ? (33'h1_0000_0000 - {1'b0, angle}) : {1'b0, angle};
            steps = 0;
            while (mag > limit && steps < P_MAX_DIVIDES) begin
                mag = (mag + 33'd1) / 33'd3;
                steps++;
            end
            r.depth_limited = mag > limit;
            x = 64'(mag) << (30 - P_ANGLE_FRAC_BITS);
            if (x > X_MAX) x = X_MAX;
            x2 = round_q30(x, x);
            x3 = round_q30(x2, x);
            s = saturate_unit(longint'(x) - longint'((x3 + 64'd3) / 64'd6));
            repeat (steps) begin
                cube = signed_q30(signed_q30(s, s), s);
                s = saturate_unit(3 * s - 4 * cube);
            end
            if (angle[ANGLE_W-1]) s = -s;
            r.sine = s[SINE_W-1:0];
            return r;
        endfunction

        function void note_angle(logic [ANGLE_W-1:0] angle);
            expected_sines.push_back(predict_sine(angle));
        endfunction

        task report_mismatch(string what);
            $display("mismatch at %0t: %s", $realtime, what);
            mismatch_count++;
        endtask

        task check_result(logic [SINE_W-1:0] sine, logic depth_limited);
            t_sine_result exp_r;
            if (expected_sines.size() == 0) begin
                report_mismatch($sformatf("unexpected result sine %h", sine));
            end else begin
                exp_r = expected_sines.pop_front();
                if (sine !== exp_r.sine)
                    report_mismatch($sformatf("sine %h, expected %h", sine, exp_r.sine));
                if (depth_limited !== exp_r.depth_limited)
                    report_mismatch($sformatf("depth_limited %b, expected %b",
                                              depth_limited, exp_r.depth_limited));
            end
        endtask
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [LIMIT_W-1:0] i_cfg_wdata;
    logic               s_axis_tvalid;
    logic               s_axis_tready;
    logic [ANGLE_W-1:0] s_axis_tdata;
    logic               m_axis_tvalid;
    logic               m_axis_tready;
    logic [SINE_W-1:0]  m_axis_tdata;
    logic               m_axis_tuser;

    t_sine_scoreboard sb;
    int               tx_idle_pct;
    int               rx_stall_pct;
    int               hold_request;

    sine_by_triple_angle DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    task automatic send_angle(input logic [ANGLE_W-1:0] angle);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= angle;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_angle(angle);
        @(negedge i_clk);
    endtask

    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (sb.expected_sines.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_limit(input logic [LIMIT_W-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.limit = value;
    endtask

    function automatic logic [ANGLE_W-1:0] random_angle();
        logic [ANGLE_W-1:0] v;
        case ($urandom_range(3))
            0: v = $urandom();
            1: v = $urandom_range(0, 2 * int'(sb.limit) + 64);
            2: v = $urandom_range(0, 32'd1686629713);
            default: v = $urandom() >> $urandom_range(31);
        endcase
        return $urandom_range(1) ? -v : v;
    endfunction

    // receiver: random stalls, plus long hold-offs on request
    initial begin
        int hold_count;
        hold_count = 0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_request != 0) begin
                hold_count   = hold_request;
                hold_request = 0;
            end
            if (hold_count > 0) begin
                m_axis_tready <= 1'b0;
                hold_count--;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata, m_axis_tuser);
    end

    initial begin
        logic [ANGLE_W-1:0] directed_angles[$];
        logic [LIMIT_W-1:0] next_limit;
        sb            = new();
        tx_idle_pct   = 0;
        rx_stall_pct  = 0;
        hold_request  = 0;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_wdata   = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        directed_angles = '{32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
                            32'h8000_0000, 32'h7FFF_FFFE, 32'd42165842, 32'd42165843,
                            -32'd42165843, 32'd126497526, 32'd126497527, 32'd421657428,
                            -32'd421657428, 32'd843314857, -32'd843314857,
                            32'd1686629713, 32'h1000_0000, -32'h1000_0000, 32'h4000_0000,
                            32'h0000_FFFF, 32'h5555_5555, 32'hAAAA_AAAA};
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        for (int p = 0; p < PHASES; p++) begin
            if (p > 0) begin
                settle();
                case (p)
                    1: next_limit = LIMIT_ALL_ONES;
                    2: next_limit = '0;
                    3: next_limit = 29'd1;
                    4: next_limit = LIMIT_ONE_RAD;
                    5: next_limit = LIMIT_W'($urandom_range(1, 32'h1FFF_FFFF));
                    default: next_limit = LIMIT_RESET;
                endcase
                write_limit(next_limit);
            end
            case (p % 4)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_idle_pct = 56; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 56; end
                default: begin tx_idle_pct = 10; rx_stall_pct = 10; end
            endcase
            if (p == 0)
                foreach (directed_angles[i]) send_angle(directed_angles[i]);
            // long receiver hold-off so the input side backs up
            if (p == 4 || p == 5) hold_request = 300;
            repeat (RANDOM_ITEMS) send_angle(random_angle());
        end
        settle();
        if (sb.mismatch_count == 0 && sb.expected_sines.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #30000000;
        $display("Test completed with failures");
        $finish;
    end

endmodule

[filelist.f]
sv/sbta_pkg.sv
sv/sbta_ctrl.sv
sv/sbta_dp.sv
sv/sine_by_triple_angle.sv
sv/sbta_checker.sv
bench/tb.sv
